// ----- rtl/mahd_pkg.sv -----
// Shared types, field codes and lookup tables for the MPEG audio header decoder.
package mahd_pkg;

   // Version codes, header byte 1 bits 4:3
   localparam logic [1:0] VER_2P5 = 2'd0;
   localparam logic [1:0] VER_RSV = 2'd1;
   localparam logic [1:0] VER_2   = 2'd2;
   localparam logic [1:0] VER_1   = 2'd3;

   // Layer codes, header byte 1 bits 2:1 (code 0 decodes as layer III)
   localparam logic [1:0] LAYER_I  = 2'd3;
   localparam logic [1:0] LAYER_II = 2'd2;

   localparam logic [1:0] MODE_MONO    = 2'd3;
   localparam logic [3:0] BIDX_BAD     = 4'hf;
   localparam logic [1:0] SIDX_BAD     = 2'd3;

   localparam logic [10:0] SAMPLES_L1   = 11'd384;
   localparam logic [10:0] SAMPLES_HALF = 11'd576;
   localparam logic [10:0] SAMPLES_FULL = 11'd1152;

   // Frame-length coefficients divided by 100 (the base rates share that factor)
   localparam logic [12:0] COEF_L1   = 13'd120;
   localparam logic [12:0] COEF_HALF = 13'd720;
   localparam logic [12:0] COEF_FULL = 13'd1440;

   // Reciprocal divider: quotient estimate is (a * recip) >> QSHIFT, low by at most one
   localparam int unsigned QSHIFT = 30;

   localparam logic [15:0] RATE_BASE [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
   localparam logic [8:0]  RATE_DIV  [4] = '{9'd441, 9'd480, 9'd320, 9'd1};
   localparam logic [21:0] RATE_RECIP [4] = '{
      22'((64'd1 << QSHIFT) / 64'd441),
      22'((64'd1 << QSHIFT) / 64'd480),
      22'((64'd1 << QSHIFT) / 64'd320),
      22'd0};

   localparam logic [8:0] KBPS_V1_L1 [16] = '{
      9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
   localparam logic [8:0] KBPS_V2_L1 [16] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam logic [8:0] KBPS_V1_L2 [16] = '{
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam logic [8:0] KBPS_V1_L3 [16] = '{
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam logic [8:0] KBPS_V2_L23 [16] = '{
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

   // Decoded fields that ride along the divider stages
   typedef struct packed {
      logic        err;
      logic        pad;
      logic        l1;
      logic [1:0]  rsel;
      logic [8:0]  kbps;
      logic [15:0] rate_hz;
      logic [1:0]  chan;
      logic [10:0] samples;
   } side_type;

endpackage

// ----- rtl/mpeg_audio_header_decoder_top.sv -----
// Top level: four-stage pipelined MPEG audio frame header decoder.
//
//   channel | dir | handshake            | beat
//   req     | in  | req_valid/req_stall  | req_header_bytes (bytes 1..3 after sync)
//   rsp     | out | rsp_valid/rsp_stall  | status, frame size, rate, channels,
//           |     |                      | bitrate, samples per frame
//
// One header per cycle sustained while rsp_stall is low; each beat moves through the stages in order.
// Stages: table decode, coefficient multiply, reciprocal multiply, remainder
// correction and output register. The reciprocal divider sets the depth.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stall on rsp holds the last stage; bubbles ahead of it keep filling, and
// req_stall rises only when every stage holds a beat.
module mpeg_audio_header_decoder_top
   import mahd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_header_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [11:0] rsp_frame_size_bytes,
   output logic [15:0] rsp_sampling_rate_hz,
   output logic [1:0]  rsp_channel_count,
   output logic [8:0]  rsp_bitrate_kbps,
   output logic [10:0] rsp_samples_per_frame
);

   // Stage valids and enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   // Advance a stage when it is empty or the stage after it moves
   assign en4 = !v4_ff || !rsp_stall;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // ---------------- Stage 1: field decode and table lookups ----------------
   logic [1:0]  ver, lcode, sidx, mode, shamt;
   logic [3:0]  bidx;
   logic        is_l1, is_l2, is_v1;
   logic [12:0] coef_base;
   side_type    sd1_in, sd1_ff, sd2_ff, sd3_ff;
   logic [12:0] coef_in, coef_ff;

   always_comb begin
      ver   = req_header_bytes[20:19];
      lcode = req_header_bytes[18:17];
      bidx  = req_header_bytes[15:12];
      sidx  = req_header_bytes[11:10];
      mode  = req_header_bytes[7:6];
      is_l1 = (lcode == LAYER_I);
      is_l2 = (lcode == LAYER_II);
      is_v1 = (ver == VER_1);

      unique case (ver)
         VER_2:   shamt = 2'd1;
         VER_2P5: shamt = 2'd2;
         default: shamt = 2'd0;
      endcase

      sd1_in.err  = (sidx == SIDX_BAD) || (bidx == BIDX_BAD) || (ver == VER_RSV);
      sd1_in.pad  = req_header_bytes[9];
      sd1_in.l1   = is_l1;
      sd1_in.rsel = sidx;
      sd1_in.rate_hz = RATE_BASE[sidx] >> shamt;
      sd1_in.chan = (mode == MODE_MONO) ? 2'd1 : 2'd2;

      priority if (is_l1) begin
         sd1_in.kbps    = is_v1 ? KBPS_V1_L1[bidx] : KBPS_V2_L1[bidx];
         sd1_in.samples = SAMPLES_L1;
         coef_base      = COEF_L1;
      end else if (is_v1) begin
         sd1_in.kbps    = is_l2 ? KBPS_V1_L2[bidx] : KBPS_V1_L3[bidx];
         sd1_in.samples = SAMPLES_FULL;
         coef_base      = COEF_FULL;
      end else if (is_l2) begin
         sd1_in.kbps    = KBPS_V2_L23[bidx];
         sd1_in.samples = SAMPLES_FULL;
         coef_base      = COEF_FULL;
      end else begin
         sd1_in.kbps    = KBPS_V2_L23[bidx];
         sd1_in.samples = SAMPLES_HALF;
         coef_base      = COEF_HALF;
      end

      // Fold the sample-rate divide by 2 or 4 into the numerator
      coef_in = coef_base << shamt;
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         sd1_ff  <= sd1_in;
         coef_ff <= coef_in;
      end
   end

   // ---------------- Stage 2: numerator = coefficient * kbps ----------------
   logic [21:0] num_full;
   logic [19:0] num_in, num2_ff, num3_ff;

   assign num_full = coef_ff * sd1_ff.kbps;
   assign num_in   = num_full[19:0];

   always_ff @(posedge clock) begin
      if (en2) begin
         sd2_ff  <= sd1_ff;
         num2_ff <= num_in;
      end
   end

   // ---------------- Stage 3: quotient estimate by reciprocal ----------------
   logic [41:0] qprod;
   logic [11:0] qest_in, qest_ff;

   assign qprod   = num2_ff * RATE_RECIP[sd2_ff.rsel];
   assign qest_in = qprod[QSHIFT +: 12];

   always_ff @(posedge clock) begin
      if (en3) begin
         sd3_ff  <= sd2_ff;
         num3_ff <= num2_ff;
         qest_ff <= qest_in;
      end
   end

   // ---------------- Stage 4: correct, add padding, register outputs ----------
   logic [20:0] back_prod;
   logic [20:0] rem;
   logic [11:0] quot, size_base, size_in;
   logic        status_ff;
   logic [11:0] size_ff;
   logic [15:0] rate_ff;
   logic [1:0]  chan_ff;
   logic [8:0]  kbps_ff;
   logic [10:0] samples_ff;

   always_comb begin
      back_prod = qest_ff * RATE_DIV[sd3_ff.rsel];
      rem       = {1'b0, num3_ff} - back_prod;
      // Estimate is low by at most one: bump when the remainder still covers a divisor
      quot      = qest_ff + 12'(rem >= 21'(RATE_DIV[sd3_ff.rsel]));
      size_base = quot + 12'(sd3_ff.pad);
      size_in   = sd3_ff.l1 ? {size_base[9:0], 2'b00} : size_base;
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         status_ff <= sd3_ff.err;
         if (sd3_ff.err) begin
            // Drop all decoded values on a reserved field
            size_ff    <= '0;
            rate_ff    <= '0;
            chan_ff    <= '0;
            kbps_ff    <= '0;
            samples_ff <= SAMPLES_FULL;
         end else begin
            size_ff    <= size_in;
            rate_ff    <= sd3_ff.rate_hz;
            chan_ff    <= sd3_ff.chan;
            kbps_ff    <= sd3_ff.kbps;
            samples_ff <= sd3_ff.samples;
         end
      end
   end

   assign rsp_valid             = v4_ff;
   assign rsp_status            = status_ff;
   assign rsp_frame_size_bytes  = size_ff;
   assign rsp_sampling_rate_hz  = rate_ff;
   assign rsp_channel_count     = chan_ff;
   assign rsp_bitrate_kbps      = kbps_ff;
   assign rsp_samples_per_frame = samples_ff;

endmodule

// ----- rtl/mahd_checker.sv -----
// Port-level checker for the MPEG audio header decoder, bound to the top level.
module mahd_checker
   import mahd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [23:0] req_header_bytes,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic [11:0] rsp_frame_size_bytes,
   input logic [15:0] rsp_sampling_rate_hz,
   input logic [1:0]  rsp_channel_count,
   input logic [8:0]  rsp_bitrate_kbps,
   input logic [10:0] rsp_samples_per_frame
);

   // A stalled result beat holds its status and size
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_frame_size_bytes))
      else $error("stalled rsp beat changed");

   // Error beats carry zeroed fields and the full-frame sample count
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_frame_size_bytes == 12'd0
         && rsp_sampling_rate_hz == 16'd0 && rsp_channel_count == 2'd0
         && rsp_bitrate_kbps == 9'd0 && rsp_samples_per_frame == SAMPLES_FULL)
      else $error("error beat with nonzero fields");

   // Layer I frames are whole slots of four bytes
   a_l1_slots: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_status && rsp_samples_per_frame == SAMPLES_L1
         |-> rsp_frame_size_bytes[1:0] == 2'b00)
      else $error("layer I frame size not a multiple of four");

   // An empty output stage never stalls the request side
   a_no_spurious_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled while output stage empty");

endmodule

bind mpeg_audio_header_decoder_top mahd_checker u_mahd_checker (.*);

// ----- tb/mpeg_audio_header_decoder_top_tb.sv -----
// Self-checking testbench for the MPEG audio frame header decoder top level.
`timescale 1ns / 1ps

module mpeg_audio_header_decoder_top_tb;
   import mahd_pkg::*;

   // Decoded view of one header, laid out like the rsp beat
   typedef struct packed {
      logic        status;
      logic [11:0] size_bytes;
      logic [15:0] rate_hz;
      logic [1:0]  channels;
      logic [8:0]  kbps;
      logic [10:0] samples;
   } hdr_info_type;

   // One stimulus row: the header and, where it is obvious, its decode typed in
   typedef struct packed {
      logic [23:0]  hdr;
      logic         fixed;
      hdr_info_type want;
   } hdr_row_type;

   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned RANDOM_ROWS  = 1928;
   localparam int unsigned TAIL_ROWS    = 150;
   localparam int unsigned MAX_REPORTS  = 60;

   // Frame-length numerators
   localparam int unsigned COEF_LAYER1 = 12000;
   localparam int unsigned COEF_LONG   = 144000;
   localparam int unsigned COEF_SHORT  = 72000;

   localparam int unsigned BASE_RATE_HZ [3] = '{44100, 48000, 32000};

   // Bitrate tables in kbit/s, index 0 is free format
   localparam int unsigned BR_M1_L1 [15] = '{
      0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448};
   localparam int unsigned BR_M2_L1 [15] = '{
      0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256};
   localparam int unsigned BR_M1_L2 [15] = '{
      0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384};
   localparam int unsigned BR_M1_L3 [15] = '{
      0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320};
   localparam int unsigned BR_M2_L23 [15] = '{
      0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160};

   // Any reserved field value decodes to this
   localparam hdr_info_type RESERVED_INFO = '{1'b1, 12'd0, 16'd0, 2'd0, 9'd0, SAMPLES_FULL};

   // Directed rows: extremes of every field, each version and layer, the reserved
   // layer code, free format with and without padding, and every reserved value.
   localparam int unsigned DIRECTED_ROWS = 22;
   localparam hdr_row_type DIRECTED [DIRECTED_ROWS] = '{
      // all zero: MPEG-2.5, reserved layer as III, free format, stereo
      '{24'h000000, 1'b1, '{1'b0, 12'd0, 16'd11025, 2'd2, 9'd0, SAMPLES_HALF}},
      // all ones: bitrate index 15 and sample-rate index 3
      '{24'hFFFFFF, 1'b1, RESERVED_INFO},
      // reserved version code
      '{24'hEA9000, 1'b1, RESERVED_INFO},
      // reserved sample-rate index
      '{24'hFB9C40, 1'b1, RESERVED_INFO},
      // bitrate index 15 alone
      '{24'hF3F000, 1'b1, RESERVED_INFO},
      // largest frame: MPEG-2.5 layer II, 160 kbit/s at 8 kHz, padded, mono
      '{24'hE5EAC0, 1'b1, '{1'b0, 12'd2881, 16'd8000, 2'd1, 9'd160, SAMPLES_FULL}},
      // top MPEG-1 layer I bitrate at 32 kHz, padded
      '{24'hFFEA00, 1'b1, '{1'b0, 12'd676, 16'd32000, 2'd2, 9'd448, SAMPLES_L1}},
      // free format layer I: only the padding slot remains
      '{24'hFF0200, 1'b1, '{1'b0, 12'd4, 16'd44100, 2'd2, 9'd0, SAMPLES_L1}},
      '{24'hFF9040, 1'b0, '0},
      '{24'hFDA480, 1'b0, '0},
      '{24'hFBB2C0, 1'b0, '0},
      '{24'hF95000, 1'b0, '0},
      '{24'hF78600, 1'b0, '0},
      '{24'hF5C840, 1'b0, '0},
      '{24'hF3E280, 1'b0, '0},
      '{24'hF114C0, 1'b0, '0},
      '{24'hE7E600, 1'b0, '0},
      '{24'hE31840, 1'b0, '0},
      '{24'h1F123F, 1'b0, '0},
      '{24'hFAD8C0, 1'b0, '0},
      '{24'hFB0000, 1'b0, '0},
      '{24'hF20A00, 1'b0, '0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [23:0] req_header_bytes = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_status;
   logic [11:0] rsp_frame_size_bytes;
   logic [15:0] rsp_sampling_rate_hz;
   logic [1:0]  rsp_channel_count;
   logic [8:0]  rsp_bitrate_kbps;
   logic [10:0] rsp_samples_per_frame;

   hdr_row_type pending_decodes [$];   // accepted headers awaiting their rsp beat
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned stall_left = 0;
   bit          idle_on = 1'b0;        // gaps and stalls allowed in this stretch

   mpeg_audio_header_decoder_top u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_header_bytes      (req_header_bytes),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_frame_size_bytes  (rsp_frame_size_bytes),
      .rsp_sampling_rate_hz  (rsp_sampling_rate_hz),
      .rsp_channel_count     (rsp_channel_count),
      .rsp_bitrate_kbps      (rsp_bitrate_kbps),
      .rsp_samples_per_frame (rsp_samples_per_frame)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Decode one header the way the block should
   function automatic hdr_info_type decode_header(input logic [23:0] hdr);
      logic [1:0]   ver;
      logic [1:0]   lcode;
      logic [3:0]   bidx;
      logic [1:0]   sidx;
      logic         pad;
      logic [1:0]   mode;
      int unsigned  rate;
      int unsigned  kbps;
      int unsigned  size;
      hdr_info_type info;
      ver   = hdr[20:19];
      lcode = hdr[18:17];
      bidx  = hdr[15:12];
      sidx  = hdr[11:10];
      pad   = hdr[9];
      mode  = hdr[7:6];
      if (sidx == SIDX_BAD || bidx == BIDX_BAD || ver == VER_RSV) begin
         return RESERVED_INFO;
      end
      rate = BASE_RATE_HZ[sidx];
      if (ver == VER_2) begin
         rate = rate / 2;
      end else if (ver == VER_2P5) begin
         rate = rate / 4;
      end
      // layer code 0 falls through to layer III everywhere below
      if (lcode == LAYER_I) begin
         kbps = (ver == VER_1) ? BR_M1_L1[bidx] : BR_M2_L1[bidx];
         size = (COEF_LAYER1 * kbps / rate + pad) * 4;
         info.samples = SAMPLES_L1;
      end else if (ver == VER_1) begin
         kbps = (lcode == LAYER_II) ? BR_M1_L2[bidx] : BR_M1_L3[bidx];
         size = COEF_LONG * kbps / rate + pad;
         info.samples = SAMPLES_FULL;
      end else begin
         kbps = BR_M2_L23[bidx];
         if (lcode == LAYER_II) begin
            size = COEF_LONG * kbps / rate + pad;
            info.samples = SAMPLES_FULL;
         end else begin
            size = COEF_SHORT * kbps / rate + pad;
            info.samples = SAMPLES_HALF;
         end
      end
      info.status     = 1'b0;
      info.size_bytes = 12'(size);
      info.rate_hz    = 16'(rate);
      info.channels   = (mode == MODE_MONO) ? 2'd1 : 2'd2;
      info.kbps       = 9'(kbps);
      return info;
   endfunction

   // Print one line per mismatch (capped) and count every one
   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic compare_decode(input hdr_info_type got, input hdr_row_type exp_row);
      hdr_info_type want;
      want = exp_row.want;
      if (got.status !== want.status)
         report_mismatch($sformatf("hdr %06h status %0d, want %0d",
                                   exp_row.hdr, got.status, want.status));
      if (got.size_bytes !== want.size_bytes)
         report_mismatch($sformatf("hdr %06h frame size %0d, want %0d",
                                   exp_row.hdr, got.size_bytes, want.size_bytes));
      if (got.rate_hz !== want.rate_hz)
         report_mismatch($sformatf("hdr %06h rate %0d, want %0d",
                                   exp_row.hdr, got.rate_hz, want.rate_hz));
      if (got.channels !== want.channels)
         report_mismatch($sformatf("hdr %06h channels %0d, want %0d",
                                   exp_row.hdr, got.channels, want.channels));
      if (got.kbps !== want.kbps)
         report_mismatch($sformatf("hdr %06h bitrate %0d, want %0d",
                                   exp_row.hdr, got.kbps, want.kbps));
      if (got.samples !== want.samples)
         report_mismatch($sformatf("hdr %06h samples %0d, want %0d",
                                   exp_row.hdr, got.samples, want.samples));
   endtask

   // Watchdog: end the run if the pipeline never drains
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // rsp side: check every accepted beat against the oldest pending decode,
   // then pick the stall for the next edge. Stalls come in bursts of random length.
   always @(posedge clock) begin : rsp_side
      hdr_info_type got;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_frame_size_bytes, rsp_sampling_rate_hz,
                    rsp_channel_count, rsp_bitrate_kbps, rsp_samples_per_frame};
            if (pending_decodes.size() == 0) begin
               report_mismatch($sformatf("rsp beat with nothing pending: %0h", got));
            end else begin
               compare_decode(got, pending_decodes.pop_front());
            end
         end
         // drop any burst in progress once a quiet stretch begins
         if (!idle_on) begin
            rsp_stall  <= 1'b0;
            stall_left <= 0;
         end else if (stall_left != 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 4) == 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
         end else begin
            rsp_stall  <= 1'b0;
         end
      end
   end

   // req side: build the table, hold reset, then walk the table one beat per
   // handshake and record the expected decode at each accepting edge.
   initial begin : req_side
      hdr_row_type rows [$];
      logic [23:0] hdr;
      int unsigned i;
      bit          quiet;

      foreach (DIRECTED[k]) begin
         rows.push_back(DIRECTED[k]);
      end
      // Mostly well-formed headers with random content, the rest raw noise
      // so that every reserved combination still shows up.
      for (i = 0; i < RANDOM_ROWS; i++) begin
         hdr = 24'($urandom);
         if ($urandom_range(0, 9) < 8) begin
            case ($urandom_range(0, 2))
               0: hdr[20:19] = VER_1;
               1: hdr[20:19] = VER_2;
               default: hdr[20:19] = VER_2P5;
            endcase
            hdr[15:12] = 4'($urandom_range(0, 14));
            hdr[11:10] = 2'($urandom_range(0, 2));
         end
         rows.push_back('{hdr, 1'b0, '0});
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < rows.size(); i++) begin
         // no gaps or rsp stalls in one stretch mid-run and in the tail
         quiet   = (i >= rows.size() - TAIL_ROWS) || (i >= 800 && i < 1000);
         idle_on = !quiet;
         if (idle_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
         req_valid        <= 1'b1;
         req_header_bytes <= rows[i].hdr;
         // hold the beat until an edge sees it unstalled
         do @(posedge clock); while (req_stall);
         if (!rows[i].fixed) begin
            rows[i].want = decode_header(rows[i].hdr);
         end
         pending_decodes.push_back(rows[i]);
      end
      req_valid <= 1'b0;

      // drain: wait for every pending decode, then a few more edges to catch strays
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/mahd_pkg.sv
rtl/mpeg_audio_header_decoder_top.sv
rtl/mahd_checker.sv
tb/mpeg_audio_header_decoder_top_tb.sv
